### hdl/jdbe_pkg.sv
// shared types and constants for the joystick and button event block
package jdbe_pkg;

  localparam int unsigned AXIS_W  = 10;
  localparam int unsigned DEB_W   = 8;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [AXIS_W-1:0] AXIS_RESET      = 10'd512;
  localparam logic [AXIS_W-1:0] DZ_LOW_RESET    = 10'd384;
  localparam logic [AXIS_W-1:0] DZ_HIGH_RESET   = 10'd640;
  localparam logic [DEB_W-1:0]  DEB_SAMP_RESET  = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DZ_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEB_SAMP = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  typedef enum logic [1:0] {
    DIR_CENTER = 2'd0,
    DIR_LEFT   = 2'd1,
    DIR_RIGHT  = 2'd2
  } dir_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_LEFT    = 3'd1,
    EV_RIGHT   = 3'd2,
    EV_PRESS   = 3'd3,
    EV_RELEASE = 3'd4
  } event_e;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic              poll;
    logic              ev0_vld;
    event_e            ev0;
    logic              ev1_vld;
    event_e            ev1;
    logic [AXIS_W-1:0] axis;
    logic              btn;
  } op_t;

endpackage

### hdl/joystick_deadzone_button_debounce_events_core.sv
// top level of the joystick dead-zone and button debounce event block
// Each sample transaction classifies the 10-bit axis against the dead zone and runs the
// button debouncer, queuing LEFT/RIGHT and PRESS/RELEASE events into a ring of
// QUEUE_DEPTH entries (QUEUE_DEPTH-1 usable, new events dropped when full). Each poll
// transaction returns one event (none when empty) with the latest axis value and the
// debounced button. The front takes one transaction per cycle while the two-entry queue
// between front and back has room. The back end handles one transaction per cycle, except
// that a sample carrying both a direction and a button event stores its two events one
// after the other, since the event ring has a single write port, and a poll waits while
// the previous result is not taken. With back-to-back input the queue normally holds one
// transaction, so each such back-end stall also stalls the input. A poll result is
// registered and valid in the cycle after the back end takes the poll from the two-entry
// queue. No clearing pass after reset.
module joystick_deadzone_button_debounce_events_core #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [jdbe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [jdbe_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic [jdbe_pkg::AXIS_W-1:0]       axis_sample_i,
  input  logic                              button_level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [jdbe_pkg::EVENT_W-1:0]      event_code_o,
  output logic [jdbe_pkg::AXIS_W-1:0]       axis_last_o,
  output logic                              button_pressed_o
);
  import jdbe_pkg::*;

  logic [AXIS_W-1:0] dz_low_q;
  logic [AXIS_W-1:0] dz_high_q;
  logic [DEB_W-1:0]  deb_samp_q;

  logic front_vld;
  logic front_rdy;
  op_t  front_op;
  logic back_vld;
  logic back_rdy;
  op_t  back_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_low_q   <= DZ_LOW_RESET;
      dz_high_q  <= DZ_HIGH_RESET;
      deb_samp_q <= DEB_SAMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DZ_LOW:   dz_low_q   <= cfg_wdata_i[AXIS_W-1:0];
        REG_DZ_HIGH:  dz_high_q  <= cfg_wdata_i[AXIS_W-1:0];
        REG_DEB_SAMP: deb_samp_q <= cfg_wdata_i[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  jdbe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .axis_sample_i  (axis_sample_i),
    .button_level_i (button_level_i),
    .dz_low_i       (dz_low_q),
    .dz_high_i      (dz_high_q),
    .deb_samples_i  (deb_samp_q),
    .op_valid_o     (front_vld),
    .op_o           (front_op),
    .op_ready_i     (front_rdy)
  );

  jdbe_op_fifo u_op_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_vld),
    .push_ready_o (front_rdy),
    .push_op_i    (front_op),
    .pop_valid_o  (back_vld),
    .pop_ready_i  (back_rdy),
    .pop_op_o     (back_op)
  );

  jdbe_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_valid_i       (back_vld),
    .op_ready_o       (back_rdy),
    .op_i             (back_op),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_code_o     (event_code_o),
    .axis_last_o      (axis_last_o),
    .button_pressed_o (button_pressed_o)
  );

endmodule

### hdl/jdbe_ram.sv
// generic single-write, single-read ram with registered read data
module jdbe_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/jdbe_front.sv
// front end: axis dead-zone classifier and button debouncer
module jdbe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [jdbe_pkg::AXIS_W-1:0]   axis_sample_i,
  input  logic                          button_level_i,
  input  logic [jdbe_pkg::AXIS_W-1:0]   dz_low_i,
  input  logic [jdbe_pkg::AXIS_W-1:0]   dz_high_i,
  input  logic [jdbe_pkg::DEB_W-1:0]    deb_samples_i,
  output logic                          op_valid_o,
  output jdbe_pkg::op_t                 op_o,
  input  logic                          op_ready_i
);
  import jdbe_pkg::*;

  logic [AXIS_W-1:0] axis_q, axis_d;
  dir_e              dir_q, dir_d, dir_new;
  logic              deb_q, deb_d;
  logic              prev_raw_q, prev_raw_d;
  logic [DEB_W-1:0]  cnt_q, cnt_d, cnt_new;
  logic              raw;
  logic              accept;
  logic              is_sample;
  logic              deb_change;

  assign in_ready_o = op_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (req_type_i == REQ_SAMPLE);
  assign raw        = ~button_level_i;

  always_comb begin
    dir_new = DIR_CENTER;
    if (axis_sample_i < dz_low_i) begin
      dir_new = DIR_LEFT;
    end else if (axis_sample_i > dz_high_i) begin
      dir_new = DIR_RIGHT;
    end

    if (raw != prev_raw_q) begin
      cnt_new = '0;
    end else if (cnt_q < deb_samples_i) begin
      cnt_new = cnt_q + 1'b1;
    end else begin
      cnt_new = cnt_q;
    end
    deb_change = (cnt_new >= deb_samples_i) && (raw != deb_q);
  end

  always_comb begin
    axis_d     = axis_q;
    dir_d      = dir_q;
    deb_d      = deb_q;
    prev_raw_d = prev_raw_q;
    cnt_d      = cnt_q;
    if (accept && is_sample) begin
      axis_d     = axis_sample_i;
      dir_d      = dir_new;
      prev_raw_d = raw;
      cnt_d      = cnt_new;
      if (deb_change) begin
        deb_d = raw;
      end
    end
  end

  always_comb begin
    op_valid_o = accept;
    op_o.poll    = !is_sample;
    op_o.ev0_vld = is_sample && (dir_new != dir_q) && (dir_new != DIR_CENTER);
    op_o.ev0     = (dir_new == DIR_LEFT) ? EV_LEFT : EV_RIGHT;
    op_o.ev1_vld = is_sample && deb_change;
    op_o.ev1     = raw ? EV_PRESS : EV_RELEASE;
    op_o.axis    = axis_q;
    op_o.btn     = deb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q     <= AXIS_RESET;
      dir_q      <= DIR_CENTER;
      deb_q      <= 1'b0;
      prev_raw_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      axis_q     <= axis_d;
      dir_q      <= dir_d;
      deb_q      <= deb_d;
      prev_raw_q <= prev_raw_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

### hdl/jdbe_op_fifo.sv
// two-entry queue of classified transactions between front and back
module jdbe_op_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  jdbe_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output jdbe_pkg::op_t pop_op_o
);
  import jdbe_pkg::*;

  op_t        slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_op_o     = slot_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/jdbe_back.sv
// back end: event ring queue, poll handling and result register
module jdbe_back #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_valid_i,
  output logic                          op_ready_o,
  input  jdbe_pkg::op_t                 op_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [jdbe_pkg::EVENT_W-1:0]  event_code_o,
  output logic [jdbe_pkg::AXIS_W-1:0]   axis_last_o,
  output logic                          button_pressed_o
);
  import jdbe_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0]   wp_q, wp_d, wp_nxt;
  logic [PTR_W-1:0]   rp_q, rp_d, rp_nxt;
  logic               half_q, half_d;
  logic               resp_vld_q, resp_vld_d;
  logic               has_ev_q, has_ev_d;
  logic [AXIS_W-1:0]  axis_q, axis_d;
  logic               btn_q, btn_d;
  logic               poll_go;
  logic               samp_go;
  logic               both;
  logic               push_req;
  logic               push_en;
  logic               pop_en;
  logic               empty;
  logic               full;
  event_e             cur_ev;
  logic [EVENT_W-1:0] rdata;

  assign wp_nxt  = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
  assign rp_nxt  = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
  assign empty   = (wp_q == rp_q);
  assign full    = (wp_nxt == rp_q);

  assign poll_go  = op_valid_i && op_i.poll && (!resp_vld_q || out_ready_i);
  assign samp_go  = op_valid_i && !op_i.poll;
  assign both     = op_i.ev0_vld && op_i.ev1_vld;
  assign push_req = samp_go && (half_q || op_i.ev0_vld || op_i.ev1_vld);
  assign cur_ev   = (half_q || !op_i.ev0_vld) ? op_i.ev1 : op_i.ev0;
  assign push_en  = push_req && !full;
  assign pop_en   = poll_go && !empty;

  assign op_ready_o = poll_go || (samp_go && (half_q || !both));

  always_comb begin
    wp_d       = push_en ? wp_nxt : wp_q;
    rp_d       = pop_en ? rp_nxt : rp_q;
    half_d     = half_q;
    resp_vld_d = resp_vld_q;
    has_ev_d   = has_ev_q;
    axis_d     = axis_q;
    btn_d      = btn_q;
    if (samp_go) begin
      half_d = !half_q && both;
    end
    if (poll_go) begin
      resp_vld_d = 1'b1;
      has_ev_d   = !empty;
      axis_d     = op_i.axis;
      btn_d      = op_i.btn;
    end else if (out_ready_i) begin
      resp_vld_d = 1'b0;
    end
  end

  jdbe_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (wp_q),
    .wdata_i (EVENT_W'(cur_ev)),
    .re_i    (pop_en),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  assign out_valid_o      = resp_vld_q;
  assign event_code_o     = has_ev_q ? rdata : EVENT_W'(EV_NONE);
  assign axis_last_o      = axis_q;
  assign button_pressed_o = btn_q;

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d;
    btn_q  <= btn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      half_q     <= 1'b0;
      resp_vld_q <= 1'b0;
      has_ev_q   <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      half_q     <= half_d;
      resp_vld_q <= resp_vld_d;
      has_ev_q   <= has_ev_d;
    end
  end

  // a stored event leaves the ring non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |=> (wp_q != rp_q))
    else $error("ring empty after event store");

  // a stalled result keeps its event code while the ram read data is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp_vld_q && !out_ready_i) |=> (resp_vld_q && $stable(event_code_o)))
    else $error("stalled event code changed");

  // second half of a sample only exists for a sample carrying two events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (op_valid_i && !op_i.poll && op_i.ev0_vld && op_i.ev1_vld))
    else $error("second event step without a two-event sample");

  // no store and no read of the ring in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_en && pop_en))
    else $error("ring store and read collide");

endmodule

### dv/joystick_deadzone_button_debounce_events_core_tb.sv
// self-checking testbench for the joystick dead-zone and button debounce event core
module testbench;
  import jdbe_pkg::*;

  localparam int unsigned QUEUE_DEPTH    = 8;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PRINT_CAP      = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    event_e            code;
    logic [AXIS_W-1:0] axis;
    logic              btn;
  } poll_result_t;

  class event_scoreboard;
    logic [AXIS_W-1:0] dz_low, dz_high, axis_now;
    logic [DEB_W-1:0]  deb_need, stable_cnt;
    dir_e              dir_now;
    logic              btn_deb, raw_prev;
    event_e            ring [QUEUE_DEPTH];
    int unsigned       wr_ptr, rd_ptr;
    poll_result_t      expected_q[$];
    int unsigned       mismatches, samples, polls, drops;
    int unsigned       ev_count [5];

    function new();
      dz_low     = DZ_LOW_RESET;
      dz_high    = DZ_HIGH_RESET;
      deb_need   = DEB_SAMP_RESET;
      axis_now   = AXIS_RESET;
      dir_now    = DIR_CENTER;
      btn_deb    = 1'b0;
      raw_prev   = 1'b0;
      stable_cnt = '0;
      wr_ptr     = 0;
      rd_ptr     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DZ_LOW:   dz_low   = val[AXIS_W-1:0];
        REG_DZ_HIGH:  dz_high  = val[AXIS_W-1:0];
        REG_DEB_SAMP: deb_need = val[DEB_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_event(event_e ev);
      if ((wr_ptr + 1) % QUEUE_DEPTH == rd_ptr) begin
        drops++;
      end else begin
        ring[wr_ptr] = ev;
        wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
        ev_count[ev]++;
      end
    endfunction

    // advance the predicted state by one accepted input transaction
    function void note_item(logic req, logic [AXIS_W-1:0] axis, logic btn);
      poll_result_t res;
      dir_e         dir_new;
      logic         raw;
      if (req == REQ_POLL) begin
        res.code = EV_NONE;
        if (wr_ptr != rd_ptr) begin
          res.code = ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        end
        res.axis = axis_now;
        res.btn  = btn_deb;
        expected_q.push_back(res);
        polls++;
      end else begin
        samples++;
        axis_now = axis;
        dir_new = DIR_CENTER;
        if (axis < dz_low) begin
          dir_new = DIR_LEFT;
        end else if (axis > dz_high) begin
          dir_new = DIR_RIGHT;
        end
        if (dir_new != dir_now) begin
          if (dir_new == DIR_LEFT) begin
            push_event(EV_LEFT);
          end else if (dir_new == DIR_RIGHT) begin
            push_event(EV_RIGHT);
          end
          dir_now = dir_new;
        end
        raw = ~btn;
        if (raw != raw_prev) begin
          stable_cnt = '0;
          raw_prev = raw;
        end else if (stable_cnt < deb_need) begin
          stable_cnt++;
        end
        if (stable_cnt >= deb_need && raw != btn_deb) begin
          btn_deb = raw;
          if (raw) begin
            push_event(EV_PRESS);
          end else begin
            push_event(EV_RELEASE);
          end
        end
      end
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatches < PRINT_CAP) begin
        $display("[%0t] error on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      mismatches++;
    endtask

    task check_result(logic [EVENT_W-1:0] code, logic [AXIS_W-1:0] axis, logic btn);
      poll_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected poll result, event_code", code, 0);
      end else begin
        want = expected_q.pop_front();
        if (code !== want.code) report_mismatch("event_code", code, want.code);
        if (axis !== want.axis) report_mismatch("axis_last", axis, want.axis);
        if (btn !== want.btn) report_mismatch("button_pressed", btn, want.btn);
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i = REQ_SAMPLE;
  logic [AXIS_W-1:0]     axis_sample_i = '0;
  logic                  button_level_i = 1'b1;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [EVENT_W-1:0]    event_code_o;
  logic [AXIS_W-1:0]     axis_last_o;
  logic                  button_pressed_o;

  event_scoreboard sb;
  bit              tx_no_gap = 1'b0;
  bit              rx_no_stall = 1'b0;
  bit              hold_req = 1'b0;
  int unsigned     quiet_cycles = 0;
  int unsigned     reg_settings = 0;

  joystick_deadzone_button_debounce_events_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .axis_sample_i    (axis_sample_i),
    .button_level_i   (button_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_code_o     (event_code_o),
    .axis_last_o      (axis_last_o),
    .button_pressed_o (button_pressed_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_item(req_type_i, axis_sample_i, button_level_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(event_code_o, axis_last_o, button_pressed_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("joystick_deadzone_button_debounce_events_core: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always begin : rx_proc
    int unsigned stall;
    @(posedge clk_i);
    if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
      out_ready_i <= 1'b1;
    end else if (rst_ni && !rx_no_stall && $urandom_range(0, 9) < 3) begin
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      out_ready_i <= 1'b0;
      repeat (stall) @(posedge clk_i);
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  function automatic int unsigned tx_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_no_gap || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic req, logic [AXIS_W-1:0] axis, logic btn);
    int unsigned gap;
    gap = tx_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    axis_sample_i  <= axis;
    button_level_i <= btn;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                              logic [CFG_DATA_W-1:0] deb, bit spare);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_DZ_LOW, REG_DZ_HIGH, REG_DEB_SAMP, REG_SPARE};
    val = '{lo, hi, deb, CFG_DATA_W'($urandom_range(0, 1023))};
    for (int i = 0; i < (spare ? 4 : 3); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    reg_settings++;
  endtask

  // button held in runs long enough to pass the debouncer, with short bounces mixed in
  task automatic run_random(int unsigned count, bit pressure);
    int unsigned       run_left;
    int                v;
    int unsigned       r;
    logic              btn_lvl;
    logic [AXIS_W-1:0] axis;
    bit                poll;
    run_left = 0;
    btn_lvl  = 1'b1;
    for (int unsigned k = 0; k < count; k++) begin
      if (pressure && k == count / 3) hold_req = 1'b1;
      poll = (pressure && hold_req) || ($urandom_range(0, 99) < 35);
      if (run_left == 0) begin
        btn_lvl  = 1'($urandom_range(0, 1));
        run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) :
                   int'(sb.deb_need) + $urandom_range(1, 3);
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        v = (r < 25) ? int'(sb.dz_low) : int'(sb.dz_high);
        v = v + int'($urandom_range(0, 3)) - 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        axis = AXIS_W'(v);
      end else if (r < 65) begin
        axis = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      end else begin
        axis = AXIS_W'($urandom_range(0, 1023));
      end
      if (!poll) run_left--;
      send_item(poll ? REQ_POLL : REQ_SAMPLE, axis, btn_lvl);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lo, hi, deb;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_regs(DZ_LOW_RESET, DZ_HIGH_RESET, CFG_DATA_W'(DEB_SAMP_RESET), 1'b0);

    // empty poll, dead-zone edges, queue overflow, drain past empty
    send_item(REQ_POLL, AXIS_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    send_item(REQ_SAMPLE, 10'd0, 1'b1);
    send_item(REQ_SAMPLE, 10'd1023, 1'b1);
    send_item(REQ_SAMPLE, 10'd512, 1'b1);
    send_item(REQ_SAMPLE, 10'd383, 1'b1);
    send_item(REQ_SAMPLE, 10'd384, 1'b1);
    send_item(REQ_SAMPLE, 10'd640, 1'b1);
    send_item(REQ_SAMPLE, 10'd641, 1'b1);
    send_item(REQ_SAMPLE, 10'd0, 1'b1);
    send_item(REQ_SAMPLE, 10'd1023, 1'b1);
    send_item(REQ_SAMPLE, 10'd0, 1'b1);
    send_item(REQ_SAMPLE, 10'd1023, 1'b1);
    repeat (8) send_item(REQ_POLL, AXIS_W'($urandom_range(0, 1023)),
                         1'($urandom_range(0, 1)));
    // press accepted on the same sample as a direction change
    repeat (3) send_item(REQ_SAMPLE, 10'd512, 1'b0);
    send_item(REQ_SAMPLE, 10'd0, 1'b0);
    repeat (2) send_item(REQ_POLL, AXIS_W'($urandom_range(0, 1023)),
                         1'($urandom_range(0, 1)));
    wait_idle();

    // widest dead zone, no debounce
    program_regs(10'd0, 10'd1023, 10'd0, 1'b1);
    run_random(150, 1'b0);
    wait_idle();

    // overlapping dead zone, longest debounce written with extra high bits
    program_regs(10'd1023, 10'd0, 10'h3FF, 1'b0);
    run_random(120, 1'b0);
    wait_idle();

    // back-to-back sender against a long result hold-off
    program_regs(10'd200, 10'd800, 10'd1, 1'b1);
    tx_no_gap = 1'b1;
    run_random(200, 1'b1);
    tx_no_gap = 1'b0;

    for (int p = 0; p < 3; p++) begin
      wait_idle();
      lo = CFG_DATA_W'($urandom_range(100, 600));
      hi = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 1023)) :
           lo + CFG_DATA_W'($urandom_range(0, 400));
      deb = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(7, 40)) :
            CFG_DATA_W'($urandom_range(0, 6));
      deb[9:8] = 2'($urandom_range(0, 3));
      program_regs(lo, hi, deb, p == 0);
      tx_no_gap   = (p == 1);
      rx_no_stall = (p == 1);
      run_random(180, 1'b0);
    end
    tx_no_gap   = 1'b0;
    rx_no_stall = 1'b0;
    wait_idle();

    $display("covered %0d samples and %0d polls over %0d register settings",
             sb.samples, sb.polls, reg_settings);
    $display("events queued: left %0d right %0d press %0d release %0d, dropped when full %0d",
             sb.ev_count[EV_LEFT], sb.ev_count[EV_RIGHT], sb.ev_count[EV_PRESS],
             sb.ev_count[EV_RELEASE], sb.drops);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("joystick_deadzone_button_debounce_events_core: match");
    end else begin
      $display("joystick_deadzone_button_debounce_events_core: mismatch");
    end
    $finish;
  end

endmodule
